// ===== rtl/core/hmmd_pkg.sv =====
// ----------------------------------------------------------------------------
// hmmd_pkg: shared types and codes for the memory map / MBC decoder
// Region codes, mapper kinds, register indexes and the result record.
// ----------------------------------------------------------------------------
package hmmd_pkg;

  // Target regions reported with each access
  typedef enum logic [3:0] {
    REGION_ROM    = 4'd0,
    REGION_CRAM   = 4'd1,
    REGION_VRAM   = 4'd2,
    REGION_WRAM   = 4'd3,
    REGION_OAM    = 4'd4,
    REGION_IO     = 4'd5,
    REGION_HRAM   = 4'd6,
    REGION_IE     = 4'd7,
    REGION_FIXED  = 4'd8,
    REGION_MAPPER = 4'd9
  } hmmd_region_e;

  // Cartridge mapper kinds; other codes ignore mapper writes
  localparam logic [2:0] KIND_NONE = 3'd0;
  localparam logic [2:0] KIND_MBC1 = 3'd1;
  localparam logic [2:0] KIND_MBC2 = 3'd2;
  localparam logic [2:0] KIND_MBC3 = 3'd3;
  localparam logic [2:0] KIND_MBC5 = 3'd4;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_MAPPER_KIND = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ROM_BANKS   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_CRAM_BYTES  = 2'd2;
  localparam int unsigned CfgDataW = 18;

  // Mapper register set
  typedef struct packed {
    logic [8:0] rom_page;
    logic [3:0] ram_page;
    logic       ram_en;
  } hmmd_mapper_t;

  // One result item
  typedef struct packed {
    hmmd_region_e region;
    logic [22:0]  physical_offset;
    logic [7:0]   fixed_data;
    logic [8:0]   current_rom_bank;
    logic [3:0]   current_ram_bank;
    logic         ram_enable_flag;
  } hmmd_result_t;

endpackage

// ===== rtl/core/handheld_memory_map_mbc_decoder_top.sv =====
// ----------------------------------------------------------------------------
// handheld_memory_map_mbc_decoder_top: memory map decoder with MBC mapper
// Decodes bus accesses to region and offset and tracks the mapper registers.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-------------------------------
//   in      | input     | in_valid_i/in_ready_o | operation, address, write_data,
//           |           |                       | vram_bank_sel, wram_bank_sel
//   out     | output    | out_valid_o/out_ready_i | region, physical_offset,
//           |           |                       | fixed_data, banks, ram enable
//   cfg     | input     | cfg_we_i              | cfg_index_i, cfg_wdata_i
//
// One access per cycle while the skid entry is empty; each result is registered
// in the output register, or in the skid entry while the output is stalled. The
// decode and mapper update are combinational ahead of the result register.
// A two-entry output stage (result register plus skid) keeps the input open
// while one result waits. Reset clears mapper and config to defaults.
// ----------------------------------------------------------------------------
module handheld_memory_map_mbc_decoder_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hmmd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [hmmd_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          operation_i,
  input  logic [15:0]                   address_i,
  input  logic [7:0]                    write_data_i,
  input  logic                          vram_bank_sel_i,
  input  logic [2:0]                    wram_bank_sel_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [3:0]                    region_o,
  output logic [22:0]                   physical_offset_o,
  output logic [7:0]                    fixed_data_o,
  output logic [8:0]                    current_rom_bank_o,
  output logic [3:0]                    current_ram_bank_o,
  output logic                          ram_enable_flag_o
);
  import hmmd_pkg::*;

  logic [2:0]   kind_q;
  logic [9:0]   rom_banks_q;
  logic [17:0]  cram_bytes_q;
  logic         in_fire, out_fire;
  hmmd_mapper_t map_cur, map_nxt;
  hmmd_region_e dec_region;
  logic [22:0]  dec_offset;
  logic [7:0]   dec_fixed;
  hmmd_result_t res_new;
  hmmd_result_t out_q, skid_q;
  logic         out_valid_q, skid_valid_q;

  assign in_ready_o = !skid_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_q && out_ready_i;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q       <= KIND_NONE;
      rom_banks_q  <= 10'd2;
      cram_bytes_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MAPPER_KIND: kind_q       <= cfg_wdata_i[2:0];
        CFG_ROM_BANKS:   rom_banks_q  <= cfg_wdata_i[9:0];
        CFG_CRAM_BYTES:  cram_bytes_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Mapper registers update on accepted writes below 8000
  hmmd_mapper u_mapper (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (in_fire && operation_i && !address_i[15]),
    .wr_addr_i (address_i[14:0]),
    .wr_data_i (write_data_i),
    .kind_i    (kind_q),
    .cur_o     (map_cur),
    .nxt_o     (map_nxt)
  );

  hmmd_decode u_decode (
    .is_write_i   (operation_i),
    .addr_i       (address_i),
    .vram_bank_i  (vram_bank_sel_i),
    .wram_bank_i  (wram_bank_sel_i),
    .rom_banks_i  (rom_banks_q),
    .cram_bytes_i (cram_bytes_q),
    .map_i        (map_cur),
    .region_o     (dec_region),
    .offset_o     (dec_offset),
    .fixed_o      (dec_fixed)
  );

  // Assemble the result with the mapper state after this access
  always_comb begin
    res_new.region           = dec_region;
    res_new.physical_offset  = dec_offset;
    res_new.fixed_data       = dec_fixed;
    res_new.current_rom_bank = map_nxt.rom_page;
    res_new.current_ram_bank = map_nxt.ram_page;
    res_new.ram_enable_flag  = map_nxt.ram_en;
  end

  // Output register and skid stage: drain skid first, else load the new transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_fire) begin
      if (out_valid_q && !out_ready_i) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) out_q <= skid_q;
    end else if (in_fire) begin
      if (out_valid_q && !out_ready_i) skid_q <= res_new;
      else                             out_q  <= res_new;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign region_o           = out_q.region;
  assign physical_offset_o  = out_q.physical_offset;
  assign fixed_data_o       = out_q.fixed_data;
  assign current_rom_bank_o = out_q.current_rom_bank;
  assign current_ram_bank_o = out_q.current_ram_bank;
  assign ram_enable_flag_o  = out_q.ram_enable_flag;

endmodule

// ===== rtl/core/hmmd_mapper.sv =====
// ----------------------------------------------------------------------------
// hmmd_mapper: cartridge mapper registers
// Holds ROM bank, RAM bank and RAM enable and applies MBC1/2/3/5 write rules.
// ----------------------------------------------------------------------------
module hmmd_mapper (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_en_i,
  input  logic [14:0]           wr_addr_i,
  input  logic [7:0]            wr_data_i,
  input  logic [2:0]            kind_i,
  output hmmd_pkg::hmmd_mapper_t cur_o,
  output hmmd_pkg::hmmd_mapper_t nxt_o
);
  import hmmd_pkg::*;

  hmmd_mapper_t state_q, state_d;
  logic         enable;
  logic [4:0]   lo5;
  logic [3:0]   lo4;
  logic [6:0]   lo7;

  // MBC1/2/3 ROM bank values of zero select bank one
  assign enable = (wr_data_i[3:0] == 4'hA);
  assign lo5    = (wr_data_i[4:0] == 5'd0) ? 5'd1 : wr_data_i[4:0];
  assign lo4    = (wr_data_i[3:0] == 4'd0) ? 4'd1 : wr_data_i[3:0];
  assign lo7    = (wr_data_i[6:0] == 7'd0) ? 7'd1 : wr_data_i[6:0];

  // Decode the write by mapper kind and address window
  always_comb begin
    state_d = state_q;
    if (wr_en_i) begin
      case (kind_i)
        KIND_MBC1: begin
          case (wr_addr_i[14:13])
            2'b00:   state_d.ram_en   = enable;
            2'b01:   state_d.rom_page = {2'b00, state_q.rom_page[6:5], lo5};
            2'b10:   state_d.ram_page = {2'b00, wr_data_i[1:0]};
            default: ;
          endcase
        end
        KIND_MBC2: begin
          if (!wr_addr_i[14]) begin
            if (wr_addr_i[8]) state_d.rom_page = {5'd0, lo4};
            else              state_d.ram_en   = enable;
          end
        end
        KIND_MBC3: begin
          case (wr_addr_i[14:13])
            2'b00:   state_d.ram_en   = enable;
            2'b01:   state_d.rom_page = {2'b00, lo7};
            2'b10:   state_d.ram_page = wr_data_i[3:0];
            default: ;
          endcase
        end
        KIND_MBC5: begin
          case (wr_addr_i[14:13])
            2'b00: state_d.ram_en = enable;
            2'b01: begin
              if (!wr_addr_i[12]) state_d.rom_page = {state_q.rom_page[8], wr_data_i};
              else state_d.rom_page = {wr_data_i[0], state_q.rom_page[7:0]};
            end
            2'b10:   state_d.ram_page = wr_data_i[3:0];
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // Hold the mapper registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{rom_page: 9'd1, ram_page: 4'd0, ram_en: 1'b0};
    end else begin
      state_q <= state_d;
    end
  end

  assign cur_o = state_q;
  assign nxt_o = state_d;

endmodule

// ===== rtl/core/hmmd_decode.sv =====
// ----------------------------------------------------------------------------
// hmmd_decode: bus address decoder
// Maps one access to a region and byte offset, or to a fixed read value.
// ----------------------------------------------------------------------------
module hmmd_decode (
  input  logic                   is_write_i,
  input  logic [15:0]            addr_i,
  input  logic                   vram_bank_i,
  input  logic [2:0]             wram_bank_i,
  input  logic [9:0]             rom_banks_i,
  input  logic [17:0]            cram_bytes_i,
  input  hmmd_pkg::hmmd_mapper_t map_i,
  output hmmd_pkg::hmmd_region_e region_o,
  output logic [22:0]            offset_o,
  output logic [7:0]             fixed_o
);
  import hmmd_pkg::*;

  logic [2:0]  wbank;
  logic [9:0]  rom_mask;
  logic [8:0]  rom_sel;
  logic [16:0] cram_off;

  // Work RAM bank zero acts as bank one
  assign wbank    = (wram_bank_i == 3'd0) ? 3'd1 : wram_bank_i;
  assign rom_mask = rom_banks_i - 10'd1;
  assign rom_sel  = map_i.rom_page & rom_mask[8:0];
  assign cram_off = {map_i.ram_page, addr_i[12:0]};

  // Walk the memory map in address order
  always_comb begin
    region_o = REGION_FIXED;
    offset_o = '0;
    fixed_o  = 8'hFF;
    if (is_write_i && !addr_i[15]) begin
      region_o = REGION_MAPPER;
      offset_o = {7'd0, addr_i};
    end else if (addr_i < 16'h4000) begin
      region_o = REGION_ROM;
      offset_o = {9'd0, addr_i[13:0]};
    end else if (addr_i < 16'h8000) begin
      if ({1'b0, rom_sel} < rom_banks_i) begin
        region_o = REGION_ROM;
        offset_o = {rom_sel, addr_i[13:0]};
      end
    end else if (addr_i < 16'hA000) begin
      region_o = REGION_VRAM;
      offset_o = {9'd0, vram_bank_i, addr_i[12:0]};
    end else if (addr_i < 16'hC000) begin
      if (map_i.ram_en && ({1'b0, cram_off} < cram_bytes_i)) begin
        region_o = REGION_CRAM;
        offset_o = {6'd0, cram_off};
      end
    end else if (addr_i < 16'hFE00) begin
      // Bank 0 window at C000/E000, switchable window at D000/F000
      region_o = REGION_WRAM;
      if (addr_i[12]) offset_o = {8'd0, wbank, addr_i[11:0]};
      else            offset_o = {11'd0, addr_i[11:0]};
    end else if (addr_i < 16'hFEA0) begin
      region_o = REGION_OAM;
      offset_o = {15'd0, addr_i[7:0]};
    end else if (addr_i < 16'hFF00) begin
      fixed_o = 8'h00;
    end else if (addr_i < 16'hFF80) begin
      region_o = REGION_IO;
      offset_o = {15'd0, addr_i[7:0]};
    end else if (addr_i != 16'hFFFF) begin
      region_o = REGION_HRAM;
      offset_o = {16'd0, addr_i[6:0]};
    end else begin
      region_o = REGION_IE;
      offset_o = 23'h7F;
    end
    if (region_o != REGION_FIXED) fixed_o = 8'h00;
  end

endmodule
